// File: rtl/psif_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psif_pkg
// Shared types, constants and Q16.16 helpers for the point internal force
// pipeline.
// ---------------------------------------------------------------------------
package psif_pkg;

    localparam int unsigned QW       = 32;
    localparam int unsigned CFG_W    = 31;
    localparam int unsigned NUM_CORN = 4;
    // stress front end register stages
    localparam int unsigned ST_DEPTH = 12;

    typedef logic signed [QW-1:0] t_q;

    localparam logic [1:0] CFG_SHEAR  = 2'd0;
    localparam logic [1:0] CFG_LAMBDA = 2'd1;
    localparam logic [1:0] CFG_AREA   = 2'd2;

    localparam logic [CFG_W-1:0] RST_SHEAR  = 31'd65536000;
    localparam logic [CFG_W-1:0] RST_LAMBDA = 31'd65536000;
    localparam logic [CFG_W-1:0] RST_AREA   = 31'd4096;

    localparam t_q Q_ONE = 32'sd65536;

    typedef struct packed {
        t_q x;
        t_q y;
    } t_vec;

    // Saturate a wide signed value to 32 bits.
    function automatic t_q sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF)       sat34 = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000) sat34 = 32'sh8000_0000;
        else                            sat34 = v[31:0];
    endfunction

    // Round half up and saturate a 64-bit raw product.
    function automatic t_q qround(input logic signed [63:0] p);
        logic signed [64:0] s;
        logic signed [48:0] r;
        s = 65'(p) + 65'sd32768;
        r = s[64:16];
        if (r > 49'sh0_7FFF_FFFF)       qround = 32'sh7FFF_FFFF;
        else if (r < -49'sh0_8000_0000) qround = 32'sh8000_0000;
        else                            qround = r[31:0];
    endfunction

    function automatic t_q qadd(input t_q a, input t_q b);
        qadd = sat34(34'(a) + 34'(b));
    endfunction

    function automatic t_q qsub(input t_q a, input t_q b);
        qsub = sat34(34'(a) - 34'(b));
    endfunction

    function automatic t_q qneg(input t_q a);
        qneg = sat34(-34'(a));
    endfunction

endpackage

// File: rtl/point_stress_internal_force_2d.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_stress_internal_force_2d
// Material point internal force: stress from F, then force on four corners.
// ---------------------------------------------------------------------------
// One material point enters per clock unless the pipe stalls. A shared stress
// pipeline (12 stages) builds area*P*F^T; four corner lanes (3 stages) apply
// it to each weight gradient in parallel, and the results are merged into one
// output register. The pipeline advances whenever the output register is empty
// or being taken, so a full, untaken output stalls the whole pipe. The user
// must make configuration writes while the block is idle for them to take
// effect on items entering after; the block does not enforce it.
module point_stress_internal_force_2d (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [31:0]  i_f_row0_col0,
    input  logic [31:0]  i_f_row0_col1,
    input  logic [31:0]  i_f_row1_col0,
    input  logic [31:0]  i_f_row1_col1,
    input  logic [31:0]  i_grad0_x,
    input  logic [31:0]  i_grad0_y,
    input  logic [31:0]  i_grad1_x,
    input  logic [31:0]  i_grad1_y,
    input  logic [31:0]  i_grad2_x,
    input  logic [31:0]  i_grad2_y,
    input  logic [31:0]  i_grad3_x,
    input  logic [31:0]  i_grad3_y,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [31:0]  o_force0_x,
    output logic [31:0]  o_force0_y,
    output logic [31:0]  o_force1_x,
    output logic [31:0]  o_force1_y,
    output logic [31:0]  o_force2_x,
    output logic [31:0]  o_force2_y,
    output logic [31:0]  o_force3_x,
    output logic [31:0]  o_force3_y
);
    localparam int unsigned ST_DEPTH = psif_pkg::ST_DEPTH;
    localparam int unsigned LATENCY  = ST_DEPTH + 3;

    logic [30:0] r_mu, r_lambda, r_area;
    logic [LATENCY-1:0] r_vld;
    logic        en;

    psif_pkg::t_q   f_in [4];
    psif_pkg::t_vec g_in [4];
    psif_pkg::t_q   r_mat [4];
    psif_pkg::t_vec g_out [4];
    psif_pkg::t_vec lane_force [4];
    psif_pkg::t_vec r_out [4];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu     <= psif_pkg::RST_SHEAR;
            r_lambda <= psif_pkg::RST_LAMBDA;
            r_area   <= psif_pkg::RST_AREA;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                psif_pkg::CFG_SHEAR:  r_mu     <= i_cfg_data;
                psif_pkg::CFG_LAMBDA: r_lambda <= i_cfg_data;
                psif_pkg::CFG_AREA:   r_area   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid shift line; last bit is the output register's valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[LATENCY-1];

    assign f_in[0] = i_f_row0_col0;
    assign f_in[1] = i_f_row0_col1;
    assign f_in[2] = i_f_row1_col0;
    assign f_in[3] = i_f_row1_col1;
    assign g_in[0] = '{x: i_grad0_x, y: i_grad0_y};
    assign g_in[1] = '{x: i_grad1_x, y: i_grad1_y};
    assign g_in[2] = '{x: i_grad2_x, y: i_grad2_y};
    assign g_in[3] = '{x: i_grad3_x, y: i_grad3_y};

    psif_stress u_stress (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_mu     (r_mu),
        .i_lambda (r_lambda),
        .i_area   (r_area),
        .i_f      (f_in),
        .i_grad   (g_in),
        .o_r      (r_mat),
        .o_grad   (g_out)
    );

    for (genvar k = 0; k < psif_pkg::NUM_CORN; k++) begin : g_lane
        psif_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_r00   (r_mat[0]),
            .i_r01   (r_mat[1]),
            .i_r10   (r_mat[2]),
            .i_r11   (r_mat[3]),
            .i_grad  (g_out[k]),
            .o_force (lane_force[k])
        );
    end

    // the lanes' final registers form the merged output register
    assign r_out = lane_force;

    assign o_force0_x = r_out[0].x;
    assign o_force0_y = r_out[0].y;
    assign o_force1_x = r_out[1].x;
    assign o_force1_y = r_out[1].y;
    assign o_force2_x = r_out[2].x;
    assign o_force2_y = r_out[2].y;
    assign o_force3_x = r_out[3].x;
    assign o_force3_y = r_out[3].y;
endmodule

// File: rtl/psif_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psif_lane
// One corner lane: force = -(R * g), four products registered, then
// round, sum and negate over two more stages.
// ---------------------------------------------------------------------------
module psif_lane (
    input  logic             i_clk,
    input  logic             i_en,
    input  psif_pkg::t_q     i_r00,
    input  psif_pkg::t_q     i_r01,
    input  psif_pkg::t_q     i_r10,
    input  psif_pkg::t_q     i_r11,
    input  psif_pkg::t_vec   i_grad,
    output psif_pkg::t_vec   o_force
);
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    psif_pkg::t_q       r_sx, r_sy;
    psif_pkg::t_vec     r_force;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= 64'(i_r00) * 64'(i_grad.x);
            r_p1 <= 64'(i_r01) * 64'(i_grad.y);
            r_p2 <= 64'(i_r10) * 64'(i_grad.x);
            r_p3 <= 64'(i_r11) * 64'(i_grad.y);
            r_sx <= psif_pkg::qadd(psif_pkg::qround(r_p0), psif_pkg::qround(r_p1));
            r_sy <= psif_pkg::qadd(psif_pkg::qround(r_p2), psif_pkg::qround(r_p3));
            r_force.x <= psif_pkg::qneg(r_sx);
            r_force.y <= psif_pkg::qneg(r_sy);
        end
    end

    assign o_force = r_force;
endmodule

// File: rtl/psif_stress.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psif_stress
// Shared front end: A=F*F^T, B=A*F, T=4*mu*(B-F), s=lambda*(det-1),
// P=T+s*cof(F), R=area*(P*F^T). Multiply ranks sit in s1, s3, s6, s9 and s11.
// Delivers R and the delayed weight gradients to the corner lanes.
// ---------------------------------------------------------------------------
module psif_stress (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [30:0]          i_mu,
    input  logic [30:0]          i_lambda,
    input  logic [30:0]          i_area,
    input  psif_pkg::t_q         i_f [4],
    input  psif_pkg::t_vec       i_grad [4],
    output psif_pkg::t_q         o_r [4],
    output psif_pkg::t_vec       o_grad [4]
);
    localparam int unsigned DEPTH = psif_pkg::ST_DEPTH;

    typedef logic signed [63:0] t_p;

    // F and gradient delay lines; index is stage number minus one
    psif_pkg::t_q   r_f [DEPTH][4];
    psif_pkg::t_vec r_g [DEPTH][4];

    // s1: F*F^T products, det products
    t_p r_a_p [4][2];
    t_p r_det_p [2];
    // s2: A, det
    psif_pkg::t_q r_a [4];
    psif_pkg::t_q r_det;
    // s3: A*F products; lambda*(det-1) product
    t_p r_b_p [4][2];
    t_p r_s_p;
    // s4: B, s
    psif_pkg::t_q r_b [4];
    psif_pkg::t_q r_s;
    // s5: D = B-F, s carried
    psif_pkg::t_q r_d [4];
    psif_pkg::t_q r_s5;
    // s6: mu*D and s*cof products
    t_p r_mu_p [4];
    t_p r_sc_p [4];
    // s7: T and s*cof rounded
    psif_pkg::t_q r_t [4];
    psif_pkg::t_q r_sc [4];
    // s8: P
    psif_pkg::t_q r_pm [4];
    // s9: P*F^T products
    t_p r_q_p [4][2];
    // s10: Q
    psif_pkg::t_q r_q [4];
    // s11: area*Q
    t_p r_rr_p [4];
    // s12: R
    psif_pkg::t_q r_r [4];

    psif_pkg::t_q n_cof [4];

    always_comb begin
        n_cof[0] = r_f[4][3];
        n_cof[1] = psif_pkg::qneg(r_f[4][2]);
        n_cof[2] = psif_pkg::qneg(r_f[4][1]);
        n_cof[3] = r_f[4][0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f[0] <= i_f;
            r_g[0] <= i_grad;
            for (int s = 1; s < DEPTH; s++) begin
                r_f[s] <= r_f[s-1];
                r_g[s] <= r_g[s-1];
            end
            // element index e = 2*i + j
            for (int e = 0; e < 4; e++) begin
                r_a_p[e][0] <= 64'(i_f[(e/2)*2]) * 64'(i_f[(e%2)*2]);
                r_a_p[e][1] <= 64'(i_f[(e/2)*2+1]) * 64'(i_f[(e%2)*2+1]);
                r_a[e] <= psif_pkg::qadd(psif_pkg::qround(r_a_p[e][0]),
                                         psif_pkg::qround(r_a_p[e][1]));
                r_b_p[e][0] <= 64'(r_a[(e/2)*2]) * 64'(r_f[1][e%2]);
                r_b_p[e][1] <= 64'(r_a[(e/2)*2+1]) * 64'(r_f[1][2+e%2]);
                r_b[e] <= psif_pkg::qadd(psif_pkg::qround(r_b_p[e][0]),
                                         psif_pkg::qround(r_b_p[e][1]));
                r_d[e] <= psif_pkg::qsub(r_b[e], r_f[3][e]);
                r_mu_p[e] <= 64'(signed'({1'b0, i_mu})) * 64'(r_d[e]);
                r_sc_p[e] <= 64'(r_s5) * 64'(n_cof[e]);
                r_t[e] <= psif_pkg::sat34(34'(psif_pkg::qround(r_mu_p[e])) <<< 2);
                r_sc[e] <= psif_pkg::qround(r_sc_p[e]);
                r_pm[e] <= psif_pkg::qadd(r_t[e], r_sc[e]);
                r_q_p[e][0] <= 64'(r_pm[(e/2)*2]) * 64'(r_f[7][(e%2)*2]);
                r_q_p[e][1] <= 64'(r_pm[(e/2)*2+1]) * 64'(r_f[7][(e%2)*2+1]);
                r_q[e] <= psif_pkg::qadd(psif_pkg::qround(r_q_p[e][0]),
                                         psif_pkg::qround(r_q_p[e][1]));
                r_rr_p[e] <= 64'(signed'({1'b0, i_area})) * 64'(r_q[e]);
                r_r[e] <= psif_pkg::qround(r_rr_p[e]);
            end
            r_det_p[0] <= 64'(i_f[0]) * 64'(i_f[3]);
            r_det_p[1] <= 64'(i_f[1]) * 64'(i_f[2]);
            r_det <= psif_pkg::qsub(psif_pkg::qround(r_det_p[0]),
                                    psif_pkg::qround(r_det_p[1]));
            r_s_p <= 64'(signed'({1'b0, i_lambda})) *
                     64'(psif_pkg::qsub(r_det, psif_pkg::Q_ONE));
            r_s   <= psif_pkg::qround(r_s_p);
            r_s5  <= r_s;
        end
    end

    assign o_r    = r_r;
    assign o_grad = r_g[DEPTH-1];
endmodule

// File: dv/tb_point_stress_internal_force_2d.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_point_stress_internal_force_2d
// Self-checking bench for the material point internal force pipeline.
// A queue-fed driver sends points with random gaps. A monitor takes the corner
// forces with random stalls and checks them against a bit-exact Q16.16 stress
// and force predictor. Configuration changes between idle phases.
// ---------------------------------------------------------------------------
module tb_point_stress_internal_force_2d;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [3:0][31:0] fm;   // F entries: 00, 01, 10, 11
        logic [7:0][31:0] gr;   // g0x, g0y, g1x, ... g3y
    } t_point;

    typedef logic [7:0][31:0] t_forces;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [30:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_point      cur_point = '0;
    t_forces     dut_forces;

    t_point  pending_points[$];
    t_forces expected_forces[$];
    int      errors = 0;
    bit      gaps_on = 1'b1;
    bit      stalls_on = 1'b1;

    logic [30:0] mu_q = psif_pkg::RST_SHEAR;
    logic [30:0] lam_q = psif_pkg::RST_LAMBDA;
    logic [30:0] area_q = psif_pkg::RST_AREA;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    point_stress_internal_force_2d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_f_row0_col0(cur_point.fm[0]), .i_f_row0_col1(cur_point.fm[1]),
        .i_f_row1_col0(cur_point.fm[2]), .i_f_row1_col1(cur_point.fm[3]),
        .i_grad0_x(cur_point.gr[0]), .i_grad0_y(cur_point.gr[1]),
        .i_grad1_x(cur_point.gr[2]), .i_grad1_y(cur_point.gr[3]),
        .i_grad2_x(cur_point.gr[4]), .i_grad2_y(cur_point.gr[5]),
        .i_grad3_x(cur_point.gr[6]), .i_grad3_y(cur_point.gr[7]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_force0_x(dut_forces[0]), .o_force0_y(dut_forces[1]),
        .o_force1_x(dut_forces[2]), .o_force1_y(dut_forces[3]),
        .o_force2_x(dut_forces[4]), .o_force2_y(dut_forces[5]),
        .o_force3_x(dut_forces[6]), .o_force3_y(dut_forces[7])
    );

    // ---------------- Q16.16 arithmetic ----------------
    function automatic psif_pkg::t_q clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return psif_pkg::t_q'(v);
    endfunction

    function automatic psif_pkg::t_q fx_mul(input psif_pkg::t_q a, input psif_pkg::t_q b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return clip32(p >>> 16);
    endfunction

    function automatic psif_pkg::t_q fx_add(input psif_pkg::t_q a, input psif_pkg::t_q b);
        return clip32(longint'(a) + longint'(b));
    endfunction

    function automatic psif_pkg::t_q fx_sub(input psif_pkg::t_q a, input psif_pkg::t_q b);
        return clip32(longint'(a) - longint'(b));
    endfunction

    function automatic psif_pkg::t_q fx_neg(input psif_pkg::t_q a);
        return clip32(-longint'(a));
    endfunction

    function automatic psif_pkg::t_q fx_dot(input psif_pkg::t_q a, input psif_pkg::t_q b,
                                            input psif_pkg::t_q c, input psif_pkg::t_q d);
        return fx_add(fx_mul(a, b), fx_mul(c, d));
    endfunction

    function automatic t_forces corner_forces(input t_point pt);
        psif_pkg::t_q f[2][2], a[2][2], b[2][2], t[2][2], cf[2][2], p[2][2], r[2][2];
        psif_pkg::t_q mu, lam, area, det, s, gx, gy;
        t_forces res;
        mu = psif_pkg::t_q'({1'b0, mu_q});
        lam = psif_pkg::t_q'({1'b0, lam_q});
        area = psif_pkg::t_q'({1'b0, area_q});
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                f[i][j] = psif_pkg::t_q'(pt.fm[2*i+j]);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                a[i][j] = fx_dot(f[i][0], f[j][0], f[i][1], f[j][1]);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++) begin
                b[i][j] = fx_dot(a[i][0], f[0][j], a[i][1], f[1][j]);
                t[i][j] = clip32(longint'(fx_mul(mu, fx_sub(b[i][j], f[i][j]))) * 4);
            end
        det = fx_sub(fx_mul(f[0][0], f[1][1]), fx_mul(f[0][1], f[1][0]));
        s = fx_mul(lam, fx_sub(det, psif_pkg::Q_ONE));
        cf[0][0] = f[1][1];
        cf[0][1] = fx_neg(f[1][0]);
        cf[1][0] = fx_neg(f[0][1]);
        cf[1][1] = f[0][0];
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                p[i][j] = fx_add(t[i][j], fx_mul(s, cf[i][j]));
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                r[i][j] = fx_mul(area, fx_dot(p[i][0], f[j][0], p[i][1], f[j][1]));
        for (int k = 0; k < 4; k++) begin
            gx = psif_pkg::t_q'(pt.gr[2*k]);
            gy = psif_pkg::t_q'(pt.gr[2*k+1]);
            res[2*k]   = fx_neg(fx_dot(r[0][0], gx, r[0][1], gy));
            res[2*k+1] = fx_neg(fx_dot(r[1][0], gx, r[1][1], gy));
        end
        return res;
    endfunction

    // ---------------- driver ----------------
    int send_gap = 0;
    always @(posedge i_clk) begin
        logic   nxt_valid;
        t_point nxt_point;
        nxt_valid = i_valid;
        nxt_point = cur_point;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_forces.push_back(corner_forces(cur_point));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                end else if (pending_points.size() > 0) begin
                    nxt_point = pending_points.pop_front();
                    nxt_valid = 1'b1;
                    send_gap = gaps_on ? $urandom_range(0, 17) : 0;
                end
            end
        end
        i_valid <= nxt_valid;
        cur_point <= nxt_point;
    end

    // ---------------- monitor ----------------
    int recv_stall = 0;
    always @(posedge i_clk) begin
        t_forces exp_f;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_forces.size() == 0) begin
                    $error("unexpected force transaction");
                    errors++;
                end else begin
                    exp_f = expected_forces.pop_front();
                    for (int k = 0; k < 8; k++)
                        if (exp_f[k] !== dut_forces[k]) begin
                            $error("force%0d_%s expected %0d actual %0d", k / 2,
                                   (k % 2) ? "y" : "x", psif_pkg::t_q'(exp_f[k]),
                                   psif_pkg::t_q'(dut_forces[k]));
                            errors++;
                        end
                end
                recv_stall = stalls_on ? $urandom_range(0, 17) : 0;
            end else if (recv_stall > 0) begin
                recv_stall = recv_stall - 1;
            end
            i_ready <= (recv_stall == 0);
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // near-identity F with modest gradients keeps most stages out of saturation
    function automatic t_point rand_point(input bit wild);
        t_point pt;
        for (int i = 0; i < 4; i++) begin
            if (wild)
                pt.fm[i] = rand_word();
            else
                pt.fm[i] = ((i == 0 || i == 3) ? 32'sd65536 : 32'sd0)
                           + $signed($urandom_range(0, 65535)) - 32'sd32768;
        end
        for (int i = 0; i < 8; i++)
            pt.gr[i] = wild ? rand_word()
                            : $signed($urandom_range(0, 262143)) - 32'sd131072;
        return pt;
    endfunction

    function automatic t_point make_point(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d,
                                          input logic [31:0] g);
        t_point pt;
        pt.fm = {d, c, b, a};
        for (int i = 0; i < 8; i++)
            pt.gr[i] = (i % 2) ? -g : g;
        return pt;
    endfunction

    task automatic write_cfg(input logic [1:0] idx, input logic [30:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            psif_pkg::CFG_SHEAR:  mu_q = val;
            psif_pkg::CFG_LAMBDA: lam_q = val;
            psif_pkg::CFG_AREA:   area_q = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sample after the edge has settled so a point just taken from the queue is seen
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_points.size() > 0 || i_valid || expected_forces.size() > 0);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        gaps_on = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
        for (int n = 0; n < count; n++)
            pending_points.push_back(rand_point($urandom_range(0, 3) == 0));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset configuration
        pending_points.push_back(make_point(0, 0, 0, 0, 0));
        pending_points.push_back(make_point(32'd65536, 0, 0, 32'd65536, 32'd65536));
        pending_points.push_back(make_point(32'd131072, 32'd16384, 32'hFFFF_C000,
                                            32'd98304, 32'h0000_8000));
        pending_points.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                            32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_points.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                            32'h8000_0000, 32'h8000_0000));
        // singular F: cofactor path with zero determinant
        pending_points.push_back(make_point(32'd65536, 32'd65536, 32'd65536,
                                            32'd65536, 32'd65536));
        // cofactor negates the most negative value
        pending_points.push_back(make_point(0, 32'h8000_0000, 32'h8000_0000, 0,
                                            32'd65536));
        pending_points.push_back(make_point(32'd65536, 0, 0, 32'd65536, 32'hFFFF_FFFF));
        pending_points.push_back(make_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000,
                                            32'hFFFF_8000, 32'h7FFF_FFFF));
        pending_points.push_back(make_point(32'hFFFF_0000, 0, 0, 32'hFFFF_0000,
                                            32'h8000_0000));
        drain();

        write_cfg(psif_pkg::CFG_SHEAR, '0);
        write_cfg(psif_pkg::CFG_LAMBDA, '0);
        write_cfg(psif_pkg::CFG_AREA, '0);
        write_cfg(CFG_UNUSED, 31'h7FFF_FFFF);
        for (int n = 0; n < 6; n++) pending_points.push_back(rand_point(n[0]));
        drain();

        write_cfg(psif_pkg::CFG_SHEAR, 31'h7FFF_FFFF);
        write_cfg(psif_pkg::CFG_LAMBDA, 31'h7FFF_FFFF);
        write_cfg(psif_pkg::CFG_AREA, 31'h7FFF_FFFF);
        pending_points.push_back(make_point(32'd65536, 0, 0, 32'd65536, 32'd65536));
        for (int n = 0; n < 6; n++) pending_points.push_back(rand_point(n[0]));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(psif_pkg::CFG_SHEAR,
                      (ph == 0) ? psif_pkg::RST_SHEAR : 31'($urandom_range(0, 200000000)));
            write_cfg(psif_pkg::CFG_LAMBDA, (ph == 1) ? 31'd0 : 31'($urandom));
            write_cfg(psif_pkg::CFG_AREA,
                      (ph == 2) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 65536)));
            random_phase(104);
            drain();
        end

        if (errors == 0 && expected_forces.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
